// ===== design/vtpg_pkg.sv =====
// Shared types and constants for the view transition parameter generator.
package vtpg_pkg;

  localparam int unsigned FracBitsDef  = 16;
  localparam int unsigned CoordBitsDef = 14;
  localparam int unsigned NumStages    = 5;

  localparam int unsigned StyleW   = 4;
  localparam int unsigned ScreenW  = 13;
  localparam int unsigned PivotW   = 12;
  localparam int unsigned OpacityW = 8;

  typedef enum logic [StyleW-1:0] {
    StyleOutNone,
    StyleInNone,
    StyleInZoom,
    StyleInMoveFade,
    StyleInRight,
    StyleInLeft,
    StyleInBounce,
    StyleInFade,
    StyleOutZoom,
    StyleOutRight,
    StyleOutLeft,
    StyleOutFade,
    StyleInZoomTl,
    StyleInZoomTr,
    StyleOutZoomTl,
    StyleOutZoomTr
  } style_e;

  typedef enum logic [1:0] {
    RegStyle,
    RegScreenW,
    RegViewW,
    RegViewH
  } reg_idx_e;

  typedef struct packed {
    style_e               style;
    logic [ScreenW-1:0]   slide_span;
    logic [PivotW-1:0]    view_width;
    logic [PivotW-1:0]    view_height;
  } cfg_t;

endpackage

// ===== design/vtpg_ease.sv =====
// Easing pipeline: quadratic in-out or bounce-out curve over three stages.
module vtpg_ease #(
  parameter int unsigned FracBits = vtpg_pkg::FracBitsDef
) (
  input  logic                  clk_i,
  input  logic [2:0]            en_i,
  input  logic [FracBits:0]     progress_i,
  input  vtpg_pkg::style_e      style_i,
  output logic [FracBits:0]     e_o
);
  import vtpg_pkg::*;

  localparam int unsigned PW   = FracBits + 1;
  localparam int unsigned MW   = FracBits + 3;
  localparam int unsigned TW   = FracBits + 6;
  localparam int unsigned OneI = 1 << FracBits;

  typedef enum logic [2:0] {
    SegQuadLo,
    SegQuadHi,
    SegB1,
    SegB2,
    SegB3,
    SegB4
  } seg_e;

  logic [PW-1:0]   p_sat;
  logic [TW-1:0]   t11, t22, dif;
  seg_e            seg_d, seg1_q, seg2_q;
  logic [MW-1:0]   ma_d, mb_d, ma_q, mb_q;
  logic [2*MW-1:0] prod_q;
  logic [MW-1:0]   e_raw;
  logic [PW-1:0]   e_d, e_q;

  // stage 1: saturate, pick segment and multiplier operands
  always_comb begin
    p_sat = (progress_i > PW'(OneI)) ? PW'(OneI) : progress_i;
    t11   = TW'(p_sat) * TW'(11);
    t22   = {t11[TW-2:0], 1'b0};
    dif   = '0;
    seg_d = SegQuadLo;
    ma_d  = MW'(p_sat);
    mb_d  = MW'({p_sat, 1'b0});
    if (style_i == StyleInBounce) begin
      if (t11 < TW'(4 * OneI)) begin
        seg_d = SegB1;
        dif   = t11;
      end else if (t11 < TW'(8 * OneI)) begin
        seg_d = SegB2;
        dif   = (t11 > TW'(6 * OneI)) ? t11 - TW'(6 * OneI) : TW'(6 * OneI) - t11;
      end else if (t11 < TW'(10 * OneI)) begin
        seg_d = SegB3;
        dif   = (t11 > TW'(9 * OneI)) ? t11 - TW'(9 * OneI) : TW'(9 * OneI) - t11;
      end else begin
        seg_d = SegB4;
        dif   = (t22 > TW'(21 * OneI)) ? t22 - TW'(21 * OneI) : TW'(21 * OneI) - t22;
      end
      ma_d = MW'(dif);
      mb_d = MW'(dif);
    end else if (p_sat >= PW'(OneI / 2)) begin
      seg_d = SegQuadHi;
      mb_d  = MW'(4 * OneI) - MW'({p_sat, 1'b0});
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      seg1_q <= seg_d;
      ma_q   <= ma_d;
      mb_q   <= mb_d;
    end
  end

  // stage 2: square / product
  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      seg2_q <= seg1_q;
      prod_q <= (2*MW)'(ma_q) * (2*MW)'(mb_q);
    end
  end

  // stage 3: scale back, add segment offset, clamp
  always_comb begin
    case (seg2_q)
      SegQuadLo: e_raw = MW'(prod_q >> FracBits);
      SegQuadHi: e_raw = MW'(prod_q >> FracBits) - MW'(OneI);
      SegB1:     e_raw = MW'(prod_q >> (FracBits + 4));
      SegB2:     e_raw = MW'(prod_q >> (FracBits + 4)) + MW'((3 * OneI) >> 2);
      SegB3:     e_raw = MW'(prod_q >> (FracBits + 4)) + MW'((15 * OneI) >> 4);
      SegB4:     e_raw = MW'(prod_q >> (FracBits + 6)) + MW'((63 * OneI) >> 6);
      default:   e_raw = '0;
    endcase
    e_d = (e_raw > MW'(OneI)) ? PW'(OneI) : e_raw[PW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      e_q <= e_d;
    end
  end

  assign e_o = e_q;

endmodule

// ===== design/vtpg_param.sv =====
// Parameter pipeline: position, opacity, scale and pivot from the eased value, plus the hide flag.
module vtpg_param #(
  parameter int unsigned FracBits  = vtpg_pkg::FracBitsDef,
  parameter int unsigned CoordBits = vtpg_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic [2:0]                        en_i,
  input  vtpg_pkg::cfg_t                    cfg_i,
  input  logic signed [CoordBits-1:0]       cx_i,
  input  logic signed [CoordBits-1:0]       cy_i,
  input  logic [FracBits:0]                 e_i,
  output logic signed [CoordBits-1:0]       new_x_o,
  output logic signed [CoordBits-1:0]       new_y_o,
  output logic                              position_written_o,
  output logic [vtpg_pkg::OpacityW-1:0]     opacity_o,
  output logic                              opacity_written_o,
  output logic [FracBits:0]                 scale_horizontal_o,
  output logic [FracBits:0]                 scale_vertical_o,
  output logic                              scale_applied_o,
  output logic [vtpg_pkg::PivotW-1:0]       pivot_x_o,
  output logic [vtpg_pkg::PivotW-1:0]       pivot_y_o,
  output logic                              hide_layer_o
);
  import vtpg_pkg::*;

  localparam int unsigned CW   = ((CoordBits > 14) ? CoordBits : 14) + 1;
  localparam int unsigned SW   = FracBits + 1;
  localparam int unsigned NW   = FracBits + 4;
  localparam int unsigned QW   = NW + SW;
  localparam int unsigned PMW  = CW - 1 + SW;
  localparam int unsigned OneI = 1 << FracBits;
  localparam int unsigned DivM = (1 << (FracBits + 4)) / 10;
  localparam logic signed [CW:0] CoordMax = (CW+1)'((1 << (CoordBits - 1)) - 1);
  localparam logic signed [CW:0] CoordMin = (CW+1)'(-(1 << (CoordBits - 1)));

  style_e               style;

  // stage 3
  logic signed [CW-1:0] cx_w, sw_w, base_d, c_d, c_abs;
  logic signed [CW-1:0] base3_q;
  logic [CW-2:0]        cmag3_q;
  logic                 cneg3_q;
  logic signed [CoordBits-1:0] cy3_q;

  // stage 4
  logic [PMW-1:0]       pm_full;
  logic [SW-1:0]        oe;
  logic [FracBits+8:0]  op_full;
  logic [NW-1:0]        num_d;
  logic [QW-1:0]        qprod;
  logic signed [CW-1:0] base4_q;
  logic [CW-2:0]        pm4_q;
  logic                 cneg4_q;
  logic signed [CoordBits-1:0] cy4_q;
  logic [OpacityW-1:0]  op4_q;
  logic [NW-1:0]        num4_q;
  logic [SW-1:0]        q04_q, e4_q;

  // stage 5
  logic [NW-1:0]        rem;
  logic [SW-1:0]        quo, scale_d;
  logic signed [CW:0]   pm_s, nx_w;
  logic signed [CoordBits-1:0] nx_d, ny_d;
  logic                 kind_tl, kind_tr, pos_w, op_w;
  logic [PivotW-1:0]    px_d, py_d;

  logic signed [CoordBits-1:0] new_x_q, new_y_q;
  logic                 position_written_q, opacity_written_q, scale_applied_q, hide_layer_q;
  logic [OpacityW-1:0]  opacity_q;
  logic [SW-1:0]        scale_q;
  logic [PivotW-1:0]    pivot_x_q, pivot_y_q;

  assign style = cfg_i.style;

  // stage 3: slide base and signed distance
  always_comb begin
    cx_w   = CW'(cx_i);
    sw_w   = CW'(signed'({1'b0, cfg_i.slide_span}));
    base_d = cx_w;
    c_d    = '0;
    case (style)
      StyleInMoveFade: begin
        base_d = CW'(100);
        c_d    = -CW'(100);
      end
      StyleInRight, StyleInBounce: begin
        base_d = sw_w;
        c_d    = -sw_w;
      end
      StyleInLeft: begin
        base_d = -sw_w;
        c_d    = sw_w;
      end
      StyleOutRight: c_d = sw_w - cx_w;
      StyleOutLeft:  c_d = -sw_w - cx_w;
      default: ;
    endcase
    c_abs = (c_d < 0) ? -c_d : c_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      base3_q <= base_d;
      cmag3_q <= c_abs[CW-2:0];
      cneg3_q <= (c_d < 0);
      cy3_q   <= cy_i;
    end
  end

  // stage 4: distance product, opacity, 0.7 scale product
  always_comb begin
    pm_full = PMW'(cmag3_q) * PMW'(e_i);
    oe      = (style inside {StyleOutZoom, StyleOutFade, StyleOutZoomTl, StyleOutZoomTr}) ?
              SW'(OneI) - e_i : e_i;
    op_full = {oe, 8'b0} - (FracBits+9)'(oe);
    num_d   = NW'(e_i) * NW'(7) +
              ((style inside {StyleInZoomTl, StyleInZoomTr}) ? NW'(3 * OneI) : NW'(0));
    qprod   = QW'(num_d) * QW'(DivM);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      base4_q <= base3_q;
      pm4_q   <= (CW-1)'(pm_full >> FracBits);
      cneg4_q <= cneg3_q;
      cy4_q   <= cy3_q;
      op4_q   <= OpacityW'(op_full >> FracBits);
      num4_q  <= num_d;
      q04_q   <= SW'(qprod >> (FracBits + 4));
      e4_q    <= e_i;
    end
  end

  // stage 5: divide correction, scale select, placement and saturation
  always_comb begin
    rem     = num4_q - NW'(q04_q) * NW'(10);
    quo     = (rem >= NW'(10)) ? q04_q + SW'(1) : q04_q;
    kind_tl = style inside {StyleInZoomTl, StyleOutZoomTl};
    kind_tr = style inside {StyleInZoomTr, StyleOutZoomTr};
    pos_w   = style inside {StyleInMoveFade, StyleInRight, StyleInLeft, StyleInBounce,
                            StyleOutRight, StyleOutLeft, StyleInZoomTl, StyleInZoomTr,
                            StyleOutZoomTl, StyleOutZoomTr};
    op_w    = style inside {StyleInZoom, StyleInMoveFade, StyleInFade, StyleOutZoom,
                            StyleOutFade, StyleInZoomTl, StyleInZoomTr, StyleOutZoomTl,
                            StyleOutZoomTr};

    case (style)
      StyleInZoom:     scale_d = SW'(OneI / 2) + (e4_q >> 1);
      StyleInMoveFade: scale_d = SW'(OneI) + ((SW'(OneI) - e4_q) >> 1);
      StyleInRight, StyleInLeft, StyleInBounce, StyleOutRight, StyleOutLeft:
                       scale_d = SW'(OneI);
      StyleOutZoom:    scale_d = SW'(OneI) - (e4_q >> 1);
      StyleInZoomTl, StyleInZoomTr:
                       scale_d = quo;
      StyleOutZoomTl:  scale_d = SW'(OneI) - e4_q;
      StyleOutZoomTr:  scale_d = SW'(OneI) - quo;
      default:         scale_d = '0;
    endcase

    pm_s = signed'((CW+1)'(pm4_q));
    if (kind_tl) begin
      nx_w = '0;
    end else if (kind_tr) begin
      nx_w = (CW+1)'(signed'({1'b0, cfg_i.slide_span})) -
             (CW+1)'(signed'({1'b0, cfg_i.view_width}));
    end else begin
      nx_w = (CW+1)'(base4_q) + (cneg4_q ? -pm_s : pm_s);
    end
    if (nx_w > CoordMax) begin
      nx_d = CoordMax[CoordBits-1:0];
    end else if (nx_w < CoordMin) begin
      nx_d = CoordMin[CoordBits-1:0];
    end else begin
      nx_d = nx_w[CoordBits-1:0];
    end
    ny_d = (kind_tl || kind_tr) ? '0 : cy4_q;

    px_d = '0;
    py_d = '0;
    if (scale_d != '0) begin
      if (kind_tr) begin
        px_d = cfg_i.view_width;
      end else if (!kind_tl) begin
        px_d = cfg_i.view_width >> 1;
        py_d = cfg_i.view_height >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      new_x_q            <= nx_d;
      new_y_q            <= ny_d;
      position_written_q <= pos_w;
      opacity_q          <= op_w ? op4_q : '0;
      opacity_written_q  <= op_w;
      scale_q            <= scale_d;
      scale_applied_q    <= (scale_d != '0);
      pivot_x_q          <= px_d;
      pivot_y_q          <= py_d;
      hide_layer_q       <= (style == StyleOutNone);
    end
  end

  assign new_x_o            = new_x_q;
  assign new_y_o            = new_y_q;
  assign position_written_o = position_written_q;
  assign opacity_o          = opacity_q;
  assign opacity_written_o  = opacity_written_q;
  assign scale_horizontal_o = scale_q;
  assign scale_vertical_o   = scale_q;
  assign scale_applied_o    = scale_applied_q;
  assign pivot_x_o          = pivot_x_q;
  assign pivot_y_o          = pivot_y_q;
  assign hide_layer_o       = hide_layer_q;

endmodule

// ===== design/view_transition_parameter_generator.sv =====
// Top level: register port, pipeline flow control, ease and parameter pipelines.
//
//  channel  | direction | handshake                    | payload
//  ---------+-----------+------------------------------+----------------------------------
//  in       | to block  | in_valid_i / in_stall_o      | progress, current_x, current_y
//  out      | from block| out_valid_o / out_stall_i    | new_x .. hide_layer
//  config   | to block  | psel, penable, pwrite, pready| four registers at 4*index
//
// One transfer per cycle in and out while out_stall_i is low; the pipeline has three ease
// stages and two output stages, set by the squaring and scaling multipliers.
// Reset clears the stage valid bits and loads the register defaults.
// Each stage holds while its successor is full and stalled; bubbles are squeezed out.
module view_transition_parameter_generator #(
  parameter int unsigned FracBits  = vtpg_pkg::FracBitsDef,
  parameter int unsigned CoordBits = vtpg_pkg::CoordBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,

  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [3:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,

  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [FracBits:0]                 progress_i,
  input  logic signed [CoordBits-1:0]       current_x_i,
  input  logic signed [CoordBits-1:0]       current_y_i,

  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [CoordBits-1:0]       new_x_o,
  output logic signed [CoordBits-1:0]       new_y_o,
  output logic                              position_written_o,
  output logic [vtpg_pkg::OpacityW-1:0]     opacity_o,
  output logic                              opacity_written_o,
  output logic [FracBits:0]                 scale_horizontal_o,
  output logic [FracBits:0]                 scale_vertical_o,
  output logic                              scale_applied_o,
  output logic [vtpg_pkg::PivotW-1:0]       pivot_x_o,
  output logic [vtpg_pkg::PivotW-1:0]       pivot_y_o,
  output logic                              hide_layer_o
);
  import vtpg_pkg::*;

  cfg_t                    cfg_d, cfg_q;
  reg_idx_e                reg_idx;
  logic [NumStages-1:0]    v_d, v_q;
  logic [NumStages:0]      en;
  logic signed [CoordBits-1:0] cx1_q, cy1_q, cx2_q, cy2_q;
  logic [FracBits:0]       e3;

  // register port
  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    case (reg_idx)
      RegStyle:   prdata = 32'(cfg_q.style);
      RegScreenW: prdata = 32'(cfg_q.slide_span);
      RegViewW:   prdata = 32'(cfg_q.view_width);
      RegViewH:   prdata = 32'(cfg_q.view_height);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite && pready) begin
      case (reg_idx)
        RegStyle:   cfg_d.style       = style_e'(pwdata[StyleW-1:0]);
        RegScreenW: cfg_d.slide_span  = pwdata[ScreenW-1:0];
        RegViewW:   cfg_d.view_width  = pwdata[PivotW-1:0];
        RegViewH:   cfg_d.view_height = pwdata[PivotW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.style       <= StyleInNone;
      cfg_q.slide_span  <= ScreenW'(480);
      cfg_q.view_width  <= PivotW'(480);
      cfg_q.view_height <= PivotW'(480);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // flow control: a stage loads when empty or when its successor moves
  always_comb begin
    en[NumStages] = !out_stall_i;
    for (int k = NumStages - 1; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
    v_d = v_q;
    if (en[0]) begin
      v_d[0] = in_valid_i;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (en[k]) begin
        v_d[k] = v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NumStages-1];

  // position alongside the ease stages
  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      cx1_q <= current_x_i;
      cy1_q <= current_y_i;
    end
    if (en[1]) begin
      cx2_q <= cx1_q;
      cy2_q <= cy1_q;
    end
  end

  vtpg_ease #(
    .FracBits (FracBits)
  ) u_ease (
    .clk_i      (clk_i),
    .en_i       (en[2:0]),
    .progress_i (progress_i),
    .style_i    (cfg_q.style),
    .e_o        (e3)
  );

  vtpg_param #(
    .FracBits  (FracBits),
    .CoordBits (CoordBits)
  ) u_param (
    .clk_i              (clk_i),
    .en_i               (en[4:2]),
    .cfg_i              (cfg_q),
    .cx_i               (cx2_q),
    .cy_i               (cy2_q),
    .e_i                (e3),
    .new_x_o            (new_x_o),
    .new_y_o            (new_y_o),
    .position_written_o (position_written_o),
    .opacity_o          (opacity_o),
    .opacity_written_o  (opacity_written_o),
    .scale_horizontal_o (scale_horizontal_o),
    .scale_vertical_o   (scale_vertical_o),
    .scale_applied_o    (scale_applied_o),
    .pivot_x_o          (pivot_x_o),
    .pivot_y_o          (pivot_y_o),
    .hide_layer_o       (hide_layer_o)
  );

endmodule

// ===== tb/view_transition_parameter_generator_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the view transition parameter generator.
module view_transition_parameter_generator_test;
  import vtpg_pkg::*;

  localparam int FracBits  = FracBitsDef;
  localparam int CoordBits = CoordBitsDef;
  localparam longint unsigned One = 64'd1 << FracBits;
  localparam longint CoordMax = (64'sd1 <<< (CoordBits - 1)) - 1;
  localparam longint CoordMin = -CoordMax - 1;
  localparam int unsigned LongHold = 300;
  localparam int unsigned CycleLimit = 600_000;

  typedef enum int {CornerNone, CornerTopLeft, CornerTopRight} zoom_corner_e;

  typedef struct packed {
    logic [FracBits:0]           progress;
    logic signed [CoordBits-1:0] cur_x;
    logic signed [CoordBits-1:0] cur_y;
  } frame_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] new_x;
    logic signed [CoordBits-1:0] new_y;
    logic                        position_written;
    logic [OpacityW-1:0]         opacity;
    logic                        opacity_written;
    logic [FracBits:0]           scale_h;
    logic [FracBits:0]           scale_v;
    logic                        scale_applied;
    logic [PivotW-1:0]           pivot_x;
    logic [PivotW-1:0]           pivot_y;
    logic                        hide_layer;
  } frame_params_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [FracBits:0] progress_i = '0;
  logic signed [CoordBits-1:0] current_x_i = '0;
  logic signed [CoordBits-1:0] current_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [CoordBits-1:0] new_x_o;
  logic signed [CoordBits-1:0] new_y_o;
  logic position_written_o;
  logic [OpacityW-1:0] opacity_o;
  logic opacity_written_o;
  logic [FracBits:0] scale_horizontal_o;
  logic [FracBits:0] scale_vertical_o;
  logic scale_applied_o;
  logic [PivotW-1:0] pivot_x_o;
  logic [PivotW-1:0] pivot_y_o;
  logic hide_layer_o;

  cfg_t model_cfg;
  frame_params_t expected_params[$];
  int unsigned fail_count = 0;
  int unsigned frames_sent = 0;
  int unsigned results_checked = 0;
  int unsigned settings_used = 0;
  int unsigned in_idle_max = 13;
  int unsigned out_idle_max = 13;
  bit hold_req = 1'b0;
  bit rx_hold = 1'b0;

  view_transition_parameter_generator i_dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .psel               (psel),
    .penable            (penable),
    .pwrite             (pwrite),
    .paddr              (paddr),
    .pwdata             (pwdata),
    .prdata             (prdata),
    .pready             (pready),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .progress_i         (progress_i),
    .current_x_i        (current_x_i),
    .current_y_i        (current_y_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .new_x_o            (new_x_o),
    .new_y_o            (new_y_o),
    .position_written_o (position_written_o),
    .opacity_o          (opacity_o),
    .opacity_written_o  (opacity_written_o),
    .scale_horizontal_o (scale_horizontal_o),
    .scale_vertical_o   (scale_vertical_o),
    .scale_applied_o    (scale_applied_o),
    .pivot_x_o          (pivot_x_o),
    .pivot_y_o          (pivot_y_o),
    .hide_layer_o       (hide_layer_o)
  );

  initial begin : clock_gen
    forever #6 clk_i = ~clk_i;
  end

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk_i);
    $display("view_transition_parameter_generator verification failed");
    $finish;
  end

  // ---------------- predictor ----------------

  function automatic longint unsigned quad_ease(input longint unsigned t);
    if (t < (One >> 1)) return (2 * t * t) >> FracBits;
    return (((4 * One - 2 * t) * t) >> FracBits) - One;
  endfunction

  function automatic longint unsigned sq_dist(input longint unsigned a, input longint unsigned b);
    longint unsigned d;
    d = (a > b) ? a - b : b - a;
    return d * d;
  endfunction

  function automatic longint unsigned bounce_ease(input longint unsigned t);
    longint unsigned t11;
    t11 = 11 * t;
    if (t11 < 4 * One) return (t11 * t11) >> (FracBits + 4);
    if (t11 < 8 * One) return (sq_dist(t11, 6 * One) >> (FracBits + 4)) + ((3 * One) >> 2);
    if (t11 < 10 * One) return (sq_dist(t11, 9 * One) >> (FracBits + 4)) + ((15 * One) >> 4);
    return (sq_dist(2 * t11, 21 * One) >> (FracBits + 6)) + ((63 * One) >> 6);
  endfunction

  // a * e / One, truncated toward zero
  function automatic longint scale_trunc(input longint a, input longint unsigned e);
    longint unsigned mag;
    longint unsigned prod;
    mag = (a < 0) ? -a : a;
    prod = (mag * e) >> FracBits;
    return (a < 0) ? -longint'(prod) : longint'(prod);
  endfunction

  function automatic logic signed [CoordBits-1:0] clamp_coord(input longint v);
    if (v > CoordMax) return CoordBits'(CoordMax);
    if (v < CoordMin) return CoordBits'(CoordMin);
    return CoordBits'(v);
  endfunction

  function automatic frame_params_t transition_params(input frame_t f);
    frame_params_t r;
    longint unsigned p, e, op, scale;
    longint nx, ny, sw, cx;
    zoom_corner_e corner;
    r = '0;
    op = 0;
    scale = 0;
    corner = CornerNone;
    cx = f.cur_x;
    nx = f.cur_x;
    ny = f.cur_y;
    sw = longint'(model_cfg.slide_span);
    p = f.progress;
    if (p > One) p = One;
    e = (model_cfg.style == StyleInBounce) ? bounce_ease(p) : quad_ease(p);
    if (e > One) e = One;
    case (model_cfg.style)
      StyleOutNone: r.hide_layer = 1'b1;
      StyleInZoom: begin
        scale = (One >> 1) + (e >> 1);
        op = (255 * e) >> FracBits;
        r.opacity_written = 1'b1;
      end
      StyleInMoveFade: begin
        scale = One + ((One - e) >> 1);
        op = (255 * e) >> FracBits;
        r.opacity_written = 1'b1;
        nx = 100 - scale_trunc(100, e);
        r.position_written = 1'b1;
      end
      StyleInRight, StyleInBounce: begin
        nx = sw - scale_trunc(sw, e);
        r.position_written = 1'b1;
        scale = One;
      end
      StyleInLeft: begin
        nx = -sw - scale_trunc(-sw, e);
        r.position_written = 1'b1;
        scale = One;
      end
      StyleInFade: begin
        op = (255 * e) >> FracBits;
        r.opacity_written = 1'b1;
      end
      StyleOutZoom: begin
        scale = One - (e >> 1);
        op = (255 * (One - e)) >> FracBits;
        r.opacity_written = 1'b1;
      end
      StyleOutRight: begin
        nx = cx + scale_trunc(sw - cx, e);
        r.position_written = 1'b1;
        scale = One;
      end
      StyleOutLeft: begin
        nx = cx + scale_trunc(-sw - cx, e);
        r.position_written = 1'b1;
        scale = One;
      end
      StyleOutFade: begin
        op = (255 * (One - e)) >> FracBits;
        r.opacity_written = 1'b1;
      end
      StyleInZoomTl, StyleInZoomTr: begin
        scale = (3 * One + 7 * e) / 10;
        op = (255 * e) >> FracBits;
        r.opacity_written = 1'b1;
        corner = (model_cfg.style == StyleInZoomTl) ? CornerTopLeft : CornerTopRight;
      end
      StyleOutZoomTl: begin
        scale = One - e;
        op = (255 * (One - e)) >> FracBits;
        r.opacity_written = 1'b1;
        corner = CornerTopLeft;
      end
      StyleOutZoomTr: begin
        scale = One - (7 * e) / 10;
        op = (255 * (One - e)) >> FracBits;
        r.opacity_written = 1'b1;
        corner = CornerTopRight;
      end
      default: ;
    endcase
    if (corner != CornerNone) begin
      r.position_written = 1'b1;
      ny = 0;
      nx = (corner == CornerTopLeft) ? 0 : sw - longint'(model_cfg.view_width);
    end
    r.new_x = clamp_coord(nx);
    r.new_y = clamp_coord(ny);
    r.opacity = op[OpacityW-1:0];
    r.scale_h = scale[FracBits:0];
    r.scale_v = scale[FracBits:0];
    r.scale_applied = (scale != 0);
    if (scale != 0) begin
      if (corner == CornerNone) begin
        r.pivot_x = model_cfg.view_width >> 1;
        r.pivot_y = model_cfg.view_height >> 1;
      end else if (corner == CornerTopRight) begin
        r.pivot_x = model_cfg.view_width;
      end
    end
    return r;
  endfunction

  // ---------------- result side ----------------

  function automatic void check_field(input string field, input logic signed [63:0] want,
                                      input logic signed [63:0] got);
    if (got !== want) begin
      fail_count++;
      $error("%s: expected %0d, actual %0d", field, want, got);
    end
  endfunction

  initial begin : result_check
    int unsigned stall_left;
    frame_params_t want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        if (expected_params.size() == 0) begin
          fail_count++;
          $error("result transfer with no frame outstanding");
        end else begin
          want = expected_params.pop_front();
          check_field("new_x", want.new_x, new_x_o);
          check_field("new_y", want.new_y, new_y_o);
          check_field("position_written", want.position_written, position_written_o);
          check_field("opacity", want.opacity, opacity_o);
          check_field("opacity_written", want.opacity_written, opacity_written_o);
          check_field("scale_horizontal", want.scale_h, scale_horizontal_o);
          check_field("scale_vertical", want.scale_v, scale_vertical_o);
          check_field("scale_applied", want.scale_applied, scale_applied_o);
          check_field("pivot_x", want.pivot_x, pivot_x_o);
          check_field("pivot_y", want.pivot_y, pivot_y_o);
          check_field("hide_layer", want.hide_layer, hide_layer_o);
        end
        results_checked++;
        stall_left = (out_idle_max == 0) ? 0 : $urandom_range(0, out_idle_max);
      end else if (stall_left > 0) begin
        stall_left--;
      end
      out_stall_i <= rx_hold || (stall_left > 0);
    end
  end

  // long receiver hold-off, started by toggling hold_req
  initial begin : receiver_hold
    bit seen_req;
    int unsigned left;
    seen_req = 1'b0;
    left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != seen_req) begin
        seen_req = hold_req;
        left = LongHold;
      end else if (left > 0) begin
        left--;
      end
      rx_hold <= (left > 0);
    end
  end

  // ---------------- stimulus helpers ----------------

  task automatic send_frame(input frame_t f);
    int unsigned gap;
    gap = (in_idle_max == 0) ? 0 : $urandom_range(0, in_idle_max);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    progress_i  <= f.progress;
    current_x_i <= f.cur_x;
    current_y_i <= f.cur_y;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    expected_params.push_back(transition_params(f));
    frames_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (expected_params.size() != 0);
    repeat (NumStages + 2) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
  endtask

  // only called with the pipeline empty
  task automatic configure(input style_e style, input int unsigned sw, input int unsigned vw,
                           input int unsigned vh);
    write_reg(RegStyle, 32'(style));
    write_reg(RegScreenW, sw);
    write_reg(RegViewW, vw);
    write_reg(RegViewH, vh);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    model_cfg.style       = style;
    model_cfg.slide_span  = ScreenW'(sw);
    model_cfg.view_width  = PivotW'(vw);
    model_cfg.view_height = PivotW'(vh);
    settings_used++;
    @(posedge clk_i);
  endtask

  function automatic frame_t random_frame();
    frame_t f;
    case ($urandom_range(0, 15))
      0:       f.progress = '0;
      1:       f.progress = (FracBits+1)'(One);
      2, 3:    f.progress = (FracBits+1)'($urandom_range(32'(One + 1), 32'(2 * One - 1)));
      default: f.progress = (FracBits+1)'($urandom_range(0, 32'(One)));
    endcase
    f.cur_x = CoordBits'($urandom);
    f.cur_y = CoordBits'($urandom);
    return f;
  endfunction

  function automatic int unsigned random_extent(input int unsigned lo, input int unsigned hi);
    case ($urandom_range(0, 5))
      0:       return lo;
      1:       return hi;
      default: return $urandom_range(lo, hi);
    endcase
  endfunction

  // ---------------- tests ----------------

  task automatic test_reset_defaults();
    send_frame('{progress: 0, cur_x: -8192, cur_y: 8191});
    send_frame('{progress: One >> 1, cur_x: 8191, cur_y: -8192});
    send_frame('{progress: One, cur_x: 0, cur_y: -1});
    wait_drained();
  endtask

  task automatic test_bounce_segment_edges();
    // each pair straddles a segment bound: 4/11, 8/11, 10/11
    int unsigned edges[6] = '{23831, 23832, 47662, 47663, 59578, 59579};
    configure(StyleInBounce, 4096, 4095, 4095);
    foreach (edges[i]) send_frame('{progress: edges[i], cur_x: 8191, cur_y: -8192});
    wait_drained();
  endtask

  task automatic test_every_style();
    int unsigned prog[8] = '{0, 1, 32767, 32768, 65535, 65536, 131071, 16384};
    logic [3:0] s;
    for (int i = 0; i < 16; i++) begin
      s = 4'(i);
      configure(style_e'(s), s[0] ? 4096 : 1, s[1] ? 4095 : 0, s[2] ? 0 : 4095);
      send_frame('{progress: prog[i % 8], cur_x: s[0] ? -8192 : 8191,
                   cur_y: s[1] ? 8191 : -8192});
      wait_drained();
    end
  endtask

  task automatic test_random_phases();
    style_e style;
    for (int ph = 0; ph < 34; ph++) begin
      style = (ph < 32) ? style_e'(ph % 16) : style_e'($urandom_range(0, 15));
      configure(style, random_extent(1, 4096), random_extent(0, 4095),
                random_extent(0, 4095));
      in_idle_max = $urandom_range(0, 1) ? 13 : 0;
      out_idle_max <= $urandom_range(0, 1) ? 13 : 0;
      repeat (50) send_frame(random_frame());
      wait_drained();
    end
  endtask

  task automatic test_output_backpressure();
    configure(StyleOutLeft, random_extent(1, 4096), random_extent(0, 4095),
              random_extent(0, 4095));
    in_idle_max = 0;
    out_idle_max <= 13;
    hold_req <= ~hold_req;
    repeat (40) send_frame(random_frame());
    wait_drained();
  endtask

  initial begin : test_sequence
    model_cfg = '{style: StyleInNone, slide_span: 480, view_width: 480, view_height: 480};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_bounce_segment_edges();
    test_every_style();
    test_random_phases();
    test_output_backpressure();
    $display("Checked %0d results of %0d frames under %0d register settings,",
             results_checked, frames_sent, settings_used);
    $display("all sixteen styles, bounce segment bounds, over-range progress, long output hold.");
    if (fail_count == 0) begin
      $display("view_transition_parameter_generator verification clean");
    end else begin
      $display("view_transition_parameter_generator verification failed");
    end
    $finish;
  end

endmodule
